FILE: rtl/c2d_pkg.sv
// c2d_pkg: shared types and constants for the streaming 2d convolution block
// no dependencies; imported by c2d_sum and conv2d_valid_stream
package c2d_pkg;

  // fixed field widths of the interface
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int SUM_W    = 40;
  localparam int IW_REG_W = 11;
  localparam int IH_REG_W = 13;
  localparam int K_REG_W  = 4;
  localparam int CFG_W    = 13;
  localparam int IDX_W    = 2;

  localparam int MAX_IMAGE_HEIGHT = 4096;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_KERNEL_HEIGHT = 2'd2,
    CFG_KERNEL_WIDTH  = 2'd3
  } cfg_idx_t;

  // per-item tag that travels beside the sum pipeline
  typedef struct packed {
    logic             fire;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

endpackage

FILE: rtl/c2d_sum.sv
// c2d_sum: window multiply and registered adder tree (products, row sums, final sum)
// depends on c2d_pkg for tag_t and SUM_W
module c2d_sum #(
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8,
  parameter int SAMPLE_BITS     = 16,
  parameter int KH_W            = 4,
  parameter int KW_W            = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [SAMPLE_BITS-1:0]       win  [MAX_KERNEL_ROWS][MAX_KERNEL_COLS],
  input  logic signed [SAMPLE_BITS-1:0]       coef [MAX_KERNEL_ROWS][MAX_KERNEL_COLS],
  input  logic [KH_W-1:0]                     kh,
  input  logic [KW_W-1:0]                     kw,
  input  c2d_pkg::tag_t                       tag_in,
  output c2d_pkg::tag_t                       tag_out,
  output logic signed [c2d_pkg::SUM_W-1:0]    sum
);
  import c2d_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 8;

  logic signed [PROD_W-1:0] prod [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];
  logic signed [ACC_W-1:0]  row_sum_next [MAX_KERNEL_ROWS];
  logic signed [ACC_W-1:0]  row_sum [MAX_KERNEL_ROWS];
  logic signed [ACC_W-1:0]  total_next;
  tag_t                     tag_p, tag_r;

  // products, masked to the kernel size in use
  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
        for (int m = 0; m < MAX_KERNEL_COLS; m++) begin
          if ((KH_W'(d) < kh) && (KW_W'(m) < kw)) begin
            prod[d][m] <= win[d][m] * coef[d][m];
          end else begin
            prod[d][m] <= '0;
          end
        end
      end
    end
  end

  // one sum per kernel row
  always_comb begin
    for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
      row_sum_next[d] = '0;
      for (int m = 0; m < MAX_KERNEL_COLS; m++) begin
        row_sum_next[d] = row_sum_next[d] + ACC_W'(prod[d][m]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_sum <= row_sum_next;
    end
  end

  // final sum over rows
  always_comb begin
    total_next = '0;
    for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
      total_next = total_next + row_sum[d];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(total_next);
    end
  end

  // tags ride alongside the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p   <= '0;
      tag_r   <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag_p   <= tag_in;
      tag_r   <= tag_p;
      tag_out <= tag_r;
    end
  end

endmodule

FILE: rtl/conv2d_valid_stream.sv
// conv2d_valid_stream: valid-mode 2d convolution over a raster pixel stream
// depends on c2d_pkg and c2d_sum
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, kind, coef_row,       | item in
//          | coef_col, sample                          |
//  out     | out_valid, out_stall, conv_sum, out_row,  | item out
//          | out_col, last                             |
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// one item per cycle while the output is not stalled; a result passes from the edge that accepts
// its pixel through five register stages
// (line store read, window shift, multiply, row sums, final sum).
// the line store is one bank per kernel row, all banks read at the pixel column.
// synchronous reset clears control, the coefficient table and the position.
// a stalled output freezes the whole pipeline and in_stall follows it.
module conv2d_valid_stream #(
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8,
  parameter int MAX_IMAGE_WIDTH = 1024,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [2:0]                          coef_row,
  input  logic [2:0]                          coef_col,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [c2d_pkg::SUM_W-1:0]    conv_sum,
  output logic [c2d_pkg::ROW_W-1:0]           out_row,
  output logic [c2d_pkg::COL_W-1:0]           out_col,
  output logic                                last,
  input  logic                                cfg_we,
  input  logic [c2d_pkg::IDX_W-1:0]           cfg_index,
  input  logic [c2d_pkg::CFG_W-1:0]           cfg_data
);
  import c2d_pkg::*;

  localparam int CW    = $clog2(MAX_IMAGE_WIDTH);
  localparam int IWC_W = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int RBW   = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
  localparam int KH_W  = $clog2(MAX_KERNEL_ROWS + 1);
  localparam int KW_W  = $clog2(MAX_KERNEL_COLS + 1);

  // configuration registers
  logic [IW_REG_W-1:0] image_width;
  logic [IH_REG_W-1:0] image_height;
  logic [K_REG_W-1:0]  kernel_height;
  logic [K_REG_W-1:0]  kernel_width;

  logic [IWC_W-1:0]    iw_c;
  logic [IH_REG_W-1:0] ih_c;
  logic [KH_W-1:0]     kh_c;
  logic [KW_W-1:0]     kw_c;

  // position of the next pixel
  logic [CW-1:0]    pix_col;
  logic [ROW_W-1:0] pix_row;
  logic [RBW-1:0]   row_bank;

  logic adv, accept, pix_we, col_end, row_end;
  tag_t in_tag;

  // stage 1
  logic                          s1_valid, s1_kind;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [2:0]                    s1_crow, s1_ccol;
  tag_t                          s1_tag;
  logic [RBW-1:0]                s1_bank;

  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_KERNEL_ROWS][MAX_IMAGE_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rd [MAX_KERNEL_ROWS];
  logic [RBW:0]                  bsel [MAX_KERNEL_ROWS];
  logic signed [SAMPLE_BITS-1:0] column [MAX_KERNEL_ROWS];

  // stage 2
  logic signed [SAMPLE_BITS-1:0] win [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];
  logic signed [SAMPLE_BITS-1:0] coef_tab [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];
  tag_t                          s2_tag, res_tag;

  // register clamping
  always_comb begin
    if (image_width == '0) iw_c = IWC_W'(1);
    else if (int'(image_width) > MAX_IMAGE_WIDTH) iw_c = IWC_W'(MAX_IMAGE_WIDTH);
    else iw_c = IWC_W'(image_width);
    if (image_height == '0) ih_c = IH_REG_W'(1);
    else if (int'(image_height) > MAX_IMAGE_HEIGHT) ih_c = IH_REG_W'(MAX_IMAGE_HEIGHT);
    else ih_c = image_height;
    if (kernel_height == '0) kh_c = KH_W'(1);
    else if (int'(kernel_height) > MAX_KERNEL_ROWS) kh_c = KH_W'(MAX_KERNEL_ROWS);
    else kh_c = KH_W'(kernel_height);
    if (kernel_width == '0) kw_c = KW_W'(1);
    else if (int'(kernel_width) > MAX_KERNEL_COLS) kw_c = KW_W'(MAX_KERNEL_COLS);
    else kw_c = KW_W'(kernel_width);
  end

  // handshake
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign pix_we   = accept && kind;

  // raster position and window tag
  assign col_end = (IWC_W'(pix_col) + IWC_W'(1)) == iw_c;
  assign row_end = (IH_REG_W'(pix_row) + IH_REG_W'(1)) == ih_c;

  always_comb begin
    in_tag.fire = ((IH_REG_W'(pix_row) + IH_REG_W'(1)) >= IH_REG_W'(kh_c)) &&
                  ((IWC_W'(pix_col) + IWC_W'(1)) >= IWC_W'(kw_c));
    in_tag.row  = ROW_W'(IH_REG_W'(pix_row) + IH_REG_W'(1) - IH_REG_W'(kh_c));
    in_tag.col  = COL_W'(IWC_W'(pix_col) + IWC_W'(1) - IWC_W'(kw_c));
    in_tag.last = row_end && col_end;
  end

  // configuration writes and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IW_REG_W'(1024);
      image_height  <= IH_REG_W'(1024);
      kernel_height <= K_REG_W'(3);
      kernel_width  <= K_REG_W'(3);
      pix_col       <= '0;
      pix_row       <= '0;
      row_bank      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data[IW_REG_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[IH_REG_W-1:0];
        CFG_KERNEL_HEIGHT: kernel_height <= cfg_data[K_REG_W-1:0];
        CFG_KERNEL_WIDTH:  kernel_width  <= cfg_data[K_REG_W-1:0];
        default: ;
      endcase
      pix_col  <= '0;
      pix_row  <= '0;
      row_bank <= '0;
    end else if (pix_we) begin
      if (col_end) begin
        pix_col <= '0;
        if (row_end) begin
          pix_row  <= '0;
          row_bank <= '0;
        end else begin
          pix_row  <= pix_row + ROW_W'(1);
          row_bank <= (row_bank == RBW'(MAX_KERNEL_ROWS - 1)) ? '0 : row_bank + RBW'(1);
        end
      end else begin
        pix_col <= pix_col + CW'(1);
      end
    end
  end

  // line store banks: write the current row, read all rows at this column
  for (genvar b = 0; b < MAX_KERNEL_ROWS; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (pix_we && (row_bank == RBW'(b))) begin
        line_mem[b][pix_col] <= sample;
      end
      if (adv) begin
        rd[b] <= line_mem[b][pix_col];
      end
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind   <= kind;
      s1_sample <= sample;
      s1_crow   <= coef_row;
      s1_ccol   <= coef_col;
      s1_tag    <= in_tag;
      s1_bank   <= row_bank;
    end
  end

  // column of the window: current pixel plus older rows from the banks
  always_comb begin
    for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
      bsel[d] = (RBW+1)'(s1_bank) + (RBW+1)'(MAX_KERNEL_ROWS - d);
      if (bsel[d] >= (RBW+1)'(MAX_KERNEL_ROWS)) begin
        bsel[d] = bsel[d] - (RBW+1)'(MAX_KERNEL_ROWS);
      end
      if (d == 0) column[d] = s1_sample;
      else column[d] = rd[bsel[d][RBW-1:0]];
    end
  end

  // window shift, newest column at index 0
  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_kind) begin
      for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
        win[d][0] <= column[d];
        for (int m = 1; m < MAX_KERNEL_COLS; m++) begin
          win[d][m] <= win[d][m-1];
        end
      end
    end
  end

  // coefficient table, written in item order with the window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
        for (int m = 0; m < MAX_KERNEL_COLS; m++) begin
          coef_tab[d][m] <= '0;
        end
      end
    end else if (adv && s1_valid && !s1_kind) begin
      for (int d = 0; d < MAX_KERNEL_ROWS; d++) begin
        for (int m = 0; m < MAX_KERNEL_COLS; m++) begin
          if ((int'(s1_crow) == d) && (int'(s1_ccol) == m)) begin
            coef_tab[d][m] <= s1_sample;
          end
        end
      end
    end
  end

  // stage 2 tag
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else if (adv) begin
      s2_tag <= {s1_tag.fire && s1_valid && s1_kind, s1_tag.row, s1_tag.col, s1_tag.last};
    end
  end

  c2d_sum #(
    .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .KH_W            (KH_W),
    .KW_W            (KW_W)
  ) u_sum (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .win     (win),
    .coef    (coef_tab),
    .kh      (kh_c),
    .kw      (kw_c),
    .tag_in  (s2_tag),
    .tag_out (res_tag),
    .sum     (conv_sum)
  );

  assign out_valid = res_tag.fire;
  assign out_row   = res_tag.row;
  assign out_col   = res_tag.col;
  assign last      = res_tag.last;

`ifndef SYNTHESIS
  // upstream is held exactly while a result waits
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output backpressure");

  // final pixel of the image wraps the position
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (pix_we && row_end && col_end) |=> (pix_row == '0 && pix_col == '0 && row_bank == '0))
    else $error("position did not wrap after the final pixel");

  // the last result sits at the bottom right of the result image
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |->
      (out_row == ROW_W'(ih_c - IH_REG_W'(kh_c)) &&
       out_col == COL_W'(iw_c - IWC_W'(kw_c))))
    else $error("last result at wrong position");
`endif

endmodule
